@@ design/inverse_time_bresenham_step_generator_defines.svh @@
// Assertion macros used by the step engine (itbsg_back).
`ifndef INVERSE_TIME_BRESENHAM_STEP_GENERATOR_DEFINES_SVH
`define INVERSE_TIME_BRESENHAM_STEP_GENERATOR_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define ITB_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ITB_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ design/itbsg_pkg.sv @@
package itbsg_pkg;

   localparam int SEG_QUEUE_DEPTH_DEF   = 8;
   localparam int BLOCK_QUEUE_DEPTH_DEF = 4;
   localparam int COUNT_BITS_DEF        = 24;

   localparam int FIELD_BITS = COUNT_BITS_DEF;
   localparam int RATE_BITS  = 30;
   localparam int POS_BITS   = 32;
   localparam int TIME_BITS  = 32;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_SEG   = 2'd1,
      REQ_BLOCK = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      LM_IDLE       = 2'd0,
      LM_NEXT_SEG   = 2'd1,
      LM_NEXT_BLOCK = 2'd2
   } load_mode_type;

   localparam int STEP_X = 2;
   localparam int STEP_Y = 3;
   localparam int STEP_Z = 4;
   localparam int DIR_X  = 5;
   localparam int DIR_Y  = 6;
   localparam int DIR_Z  = 7;

   localparam int REG_FLIP_MASK = 0;

   // Classified word handed from the front to the back.
   typedef struct packed {
      req_kind_type            kind;
      logic [FIELD_BITS-1:0]   seg_event_count;
      logic [RATE_BITS-1:0]    seg_rate;
      logic                    seg_end_of_block;
      logic [FIELD_BITS-1:0]   steps_x;
      logic [FIELD_BITS-1:0]   steps_y;
      logic [FIELD_BITS-1:0]   steps_z;
      logic [FIELD_BITS-1:0]   total_events;
      logic [7:0]              direction;
      logic [RATE_BITS-1:0]    d_next;
   } cmd_type;

   // Result word.
   typedef struct packed {
      logic [7:0]           port_bits;
      logic                 pulse_now;
      logic [POS_BITS-1:0]  pos_x;
      logic [POS_BITS-1:0]  pos_y;
      logic [POS_BITS-1:0]  pos_z;
      logic                 cycle_stop;
      logic                 push_refused;
   } rsp_type;

endpackage

@@ design/inverse_time_bresenham_step_generator.sv @@
// Three-axis inverse-time step generator.
// Requests enter through a queue port (req_push / req_full): a timer tick,
// a segment push or a block push. Every accepted word yields exactly one
// result word on the rsp_ queue port (rsp_empty / rsp_pop): the port byte
// driven this tick, pulse flag, three wrapping positions, cycle stop and
// push refused.
// A front queue holds incoming words; the back engine executes one word per
// cycle while the output queue has room, so throughput is one word per clock.
// A result word is registered in the front queue and then in the output
// queue, into which the engine executes it; it is shown on the rsp_ ports
// and can be popped from there.
// When rsp_pop stays low the two-entry output queue fills, the engine stops,
// and the front queue then fills and raises req_full; nothing is lost.
// Reset (synchronous, active high) empties all queues, zeroes positions and
// counters and arms a block load for the first tick.
// The step and direction polarity mask is written through the csr_ APB port
// at address 0.
module inverse_time_bresenham_step_generator #(
   parameter int SEG_QUEUE_DEPTH   = itbsg_pkg::SEG_QUEUE_DEPTH_DEF,
   parameter int BLOCK_QUEUE_DEPTH = itbsg_pkg::BLOCK_QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_req_type,
   input  logic [itbsg_pkg::COUNT_BITS_DEF-1:0] req_seg_event_count,
   input  logic [29:0]           req_seg_rate,
   input  logic                  req_seg_end_of_block,
   input  logic [itbsg_pkg::COUNT_BITS_DEF-1:0] req_block_steps_x,
   input  logic [itbsg_pkg::COUNT_BITS_DEF-1:0] req_block_steps_y,
   input  logic [itbsg_pkg::COUNT_BITS_DEF-1:0] req_block_steps_z,
   input  logic [itbsg_pkg::COUNT_BITS_DEF-1:0] req_block_total_events,
   input  logic [7:0]            req_block_direction,
   input  logic [29:0]           req_block_d_next,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_port_bits,
   output logic                  rsp_pulse_now,
   output logic signed [31:0]    rsp_pos_x,
   output logic signed [31:0]    rsp_pos_y,
   output logic signed [31:0]    rsp_pos_z,
   output logic                  rsp_cycle_stop,
   output logic                  rsp_push_refused,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [1:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import itbsg_pkg::*;

   cmd_type    cin, cq;
   rsp_type    r;
   logic       cq_valid, cq_take, r_valid;
   logic [7:0] mask;

   // Pack the request word.
   always_comb begin
      cin                  = '0;
      cin.kind             = req_kind_type'(req_req_type);
      cin.seg_event_count  = FIELD_BITS'(req_seg_event_count);
      cin.seg_rate         = req_seg_rate;
      cin.seg_end_of_block = req_seg_end_of_block;
      cin.steps_x          = FIELD_BITS'(req_block_steps_x);
      cin.steps_y          = FIELD_BITS'(req_block_steps_y);
      cin.steps_z          = FIELD_BITS'(req_block_steps_z);
      cin.total_events     = FIELD_BITS'(req_block_total_events);
      cin.direction        = req_block_direction;
      cin.d_next           = req_block_d_next;
   end

   itbsg_csr u_csr (
      .clock, .reset, .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .flip_mask(mask)
   );

   itbsg_front #(.DEPTH(2)) u_front (
      .clock, .reset, .push(req_push), .full(req_full), .cmd_in(cin),
      .cmd_valid(cq_valid), .cmd_take(cq_take), .cmd_out(cq)
   );

   itbsg_back #(
      .SEG_QUEUE_DEPTH(SEG_QUEUE_DEPTH), .BLOCK_QUEUE_DEPTH(BLOCK_QUEUE_DEPTH)
   ) u_back (
      .clock, .reset, .flip_mask(mask), .cmd_valid(cq_valid), .cmd_take(cq_take),
      .cmd(cq), .rsp_valid(r_valid), .rsp_take(rsp_pop), .rsp(r)
   );

   assign rsp_empty        = !r_valid;
   assign rsp_port_bits    = r.port_bits;
   assign rsp_pulse_now    = r.pulse_now;
   assign rsp_pos_x        = r.pos_x;
   assign rsp_pos_y        = r.pos_y;
   assign rsp_pos_z        = r.pos_z;
   assign rsp_cycle_stop   = r.cycle_stop;
   assign rsp_push_refused = r.push_refused;
endmodule

@@ design/itbsg_front.sv @@
// Input side: a small queue of request words that decouples the requester
// from the step engine.
module itbsg_front #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  itbsg_pkg::cmd_type cmd_in,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output itbsg_pkg::cmd_type cmd_out
);
   import itbsg_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type        mem_ff [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_out   = mem_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   // Pointer and count update.
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= cmd_in;
      end
   end
endmodule

@@ design/itbsg_back.sv @@
// Step engine: segment and block queues, inverse-time counter, Bresenham
// counters and positions. One request word per cycle while the output queue
// has room; results go to an output queue.
module itbsg_back #(
   parameter int SEG_QUEUE_DEPTH   = 8,
   parameter int BLOCK_QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         flip_mask,
   input  logic               cmd_valid,
   output logic               cmd_take,
   input  itbsg_pkg::cmd_type cmd,
   output logic               rsp_valid,
   input  logic               rsp_take,
   output itbsg_pkg::rsp_type rsp
);
   import itbsg_pkg::*;
   `include "inverse_time_bresenham_step_generator_defines.svh"

   localparam int COUNT_BITS = COUNT_BITS_DEF;
   localparam int SAW = $clog2(SEG_QUEUE_DEPTH);
   localparam int BAW = $clog2(BLOCK_QUEUE_DEPTH);
   localparam int BW  = COUNT_BITS + 2;
   localparam int OQ  = 2;

   // Segment queue.
   logic [COUNT_BITS-1:0] sq_count_ff [SEG_QUEUE_DEPTH];
   logic [RATE_BITS-1:0]  sq_rate_ff  [SEG_QUEUE_DEPTH];
   logic                  sq_eob_ff   [SEG_QUEUE_DEPTH];
   logic [SAW-1:0]        sq_head_ff, sq_head_in, sq_slot;
   logic [SAW:0]          sq_fill_ff, sq_fill_in, sq_sum;

   // Block queue.
   logic [COUNT_BITS-1:0] bq_sx_ff [BLOCK_QUEUE_DEPTH];
   logic [COUNT_BITS-1:0] bq_sy_ff [BLOCK_QUEUE_DEPTH];
   logic [COUNT_BITS-1:0] bq_sz_ff [BLOCK_QUEUE_DEPTH];
   logic [COUNT_BITS-1:0] bq_tot_ff[BLOCK_QUEUE_DEPTH];
   logic [7:0]            bq_dir_ff[BLOCK_QUEUE_DEPTH];
   logic [RATE_BITS-1:0]  bq_dn_ff [BLOCK_QUEUE_DEPTH];
   logic [BAW-1:0]        bq_head_ff, bq_head_in, bq_slot;
   logic [BAW:0]          bq_fill_ff, bq_fill_in, bq_sum;

   // Engine state.
   logic signed [BW-1:0]        bx_ff, by_ff, bz_ff, bx_in, by_in, bz_in;
   logic signed [TIME_BITS-1:0] tc_ff, tc_in;
   logic [RATE_BITS-1:0]        rate_ff, rate_in;
   logic [COUNT_BITS-1:0]       ev_ff, ev_in;
   logic [7:0]                  pbits_ff, pbits_in;
   logic                        ppulse_ff, ppulse_in;
   load_mode_type               lm_ff, lm_in;
   logic [POS_BITS-1:0]         px_ff, py_ff, pz_ff, px_in, py_in, pz_in;

   // Output queue.
   rsp_type       oq_ff [OQ];
   logic          oq_wr_ff, oq_rd_ff;
   logic [1:0]    oq_cnt_ff;
   logic          fire;
   rsp_type       res;

   assign cmd_take  = cmd_valid && (oq_cnt_ff != 2'(OQ));
   assign fire      = cmd_take;
   assign rsp_valid = (oq_cnt_ff != '0);
   assign rsp       = oq_ff[oq_rd_ff];

   // Tail slots: head plus fill, folded back once past the depth.
   assign sq_sum  = {1'b0, sq_head_ff} + sq_fill_ff;
   assign sq_slot = (sq_sum >= (SAW+1)'(SEG_QUEUE_DEPTH)) ?
                    SAW'(sq_sum - (SAW+1)'(SEG_QUEUE_DEPTH)) : SAW'(sq_sum);
   assign bq_sum  = {1'b0, bq_head_ff} + bq_fill_ff;
   assign bq_slot = (bq_sum >= (BAW+1)'(BLOCK_QUEUE_DEPTH)) ?
                    BAW'(bq_sum - (BAW+1)'(BLOCK_QUEUE_DEPTH)) : BAW'(bq_sum);

   // One Bresenham axis step.
   function automatic logic [BW:0] bres(input logic signed [BW-1:0] c,
                                        input logic [COUNT_BITS-1:0] s,
                                        input logic [COUNT_BITS-1:0] t);
      logic signed [BW-1:0] d;
      d = c - BW'(s);
      if (d[BW-1]) begin
         return {1'b1, BW'(d + BW'(t))};
      end
      return {1'b0, d};
   endfunction

   // Request execution.
   always_comb begin
      logic [BW:0]          rx, ry, rz;
      logic [7:0]           bits;
      logic [COUNT_BITS-1:0] cs_x, cs_y, cs_z, ctot;
      logic [RATE_BITS-1:0]  cdn;
      logic                  stop_tick;
      sq_head_in = sq_head_ff; sq_fill_in = sq_fill_ff;
      bq_head_in = bq_head_ff; bq_fill_in = bq_fill_ff;
      bx_in = bx_ff; by_in = by_ff; bz_in = bz_ff;
      tc_in = tc_ff; rate_in = rate_ff; ev_in = ev_ff;
      pbits_in = pbits_ff; ppulse_in = ppulse_ff; lm_in = lm_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      res = '0;
      stop_tick = 1'b0;
      cs_x = bq_sx_ff[bq_head_ff]; cs_y = bq_sy_ff[bq_head_ff];
      cs_z = bq_sz_ff[bq_head_ff]; ctot = bq_tot_ff[bq_head_ff];
      cdn  = bq_dn_ff[bq_head_ff];
      rx = '0; ry = '0; rz = '0; bits = '0;
      unique case (cmd.kind)
         REQ_TICK: begin
            if (ppulse_ff) begin
               res.port_bits = pbits_ff;
               res.pulse_now = 1'b1;
               ppulse_in     = 1'b0;
            end
            if (lm_ff != LM_IDLE) begin
               if (sq_fill_ff == '0 ||
                   (lm_ff == LM_NEXT_BLOCK && bq_fill_ff == '0)) begin
                  res.cycle_stop = 1'b1;
                  stop_tick      = 1'b1;
               end else begin
                  ev_in   = sq_count_ff[sq_head_ff];
                  rate_in = sq_rate_ff[sq_head_ff];
                  if (lm_ff == LM_NEXT_BLOCK) begin
                     pbits_in  = bq_dir_ff[bq_head_ff] ^ flip_mask;
                     ppulse_in = 1'b1;
                     bx_in = BW'(ctot >> 1); by_in = BW'(ctot >> 1);
                     bz_in = BW'(ctot >> 1);
                     tc_in = TIME_BITS'(cdn);
                  end
                  lm_in = LM_IDLE;
               end
            end
            if (!stop_tick) begin
               tc_in = tc_in - TIME_BITS'(rate_in);
               if (tc_in[TIME_BITS-1]) begin
                  tc_in     = tc_in + TIME_BITS'(cdn);
                  bits      = bq_dir_ff[bq_head_ff];
                  ppulse_in = 1'b1;
                  rx = bres(bx_in, cs_x, ctot);
                  ry = bres(by_in, cs_y, ctot);
                  rz = bres(bz_in, cs_z, ctot);
                  bx_in = rx[BW-1:0]; by_in = ry[BW-1:0]; bz_in = rz[BW-1:0];
                  bits[STEP_X] = bits[STEP_X] | rx[BW];
                  bits[STEP_Y] = bits[STEP_Y] | ry[BW];
                  bits[STEP_Z] = bits[STEP_Z] | rz[BW];
                  if (rx[BW]) px_in = bits[DIR_X] ? px_ff - 1'b1 : px_ff + 1'b1;
                  if (ry[BW]) py_in = bits[DIR_Y] ? py_ff - 1'b1 : py_ff + 1'b1;
                  if (rz[BW]) pz_in = bits[DIR_Z] ? pz_ff - 1'b1 : pz_ff + 1'b1;
                  ev_in = ev_in - 1'b1;
                  if (ev_in == '0) begin
                     if (sq_eob_ff[sq_head_ff]) begin
                        if (bq_fill_ff != '0) begin
                           bq_head_in = (bq_head_ff == BAW'(BLOCK_QUEUE_DEPTH-1)) ?
                                        '0 : bq_head_ff + 1'b1;
                           bq_fill_in = bq_fill_ff - 1'b1;
                        end
                        lm_in = LM_NEXT_BLOCK;
                     end else begin
                        lm_in = LM_NEXT_SEG;
                     end
                     if (sq_fill_ff != '0) begin
                        sq_head_in = (sq_head_ff == SAW'(SEG_QUEUE_DEPTH-1)) ?
                                     '0 : sq_head_ff + 1'b1;
                        sq_fill_in = sq_fill_ff - 1'b1;
                     end
                  end
                  pbits_in = bits ^ flip_mask;
               end
            end
         end
         REQ_SEG: begin
            if (sq_fill_ff == (SAW+1)'(SEG_QUEUE_DEPTH)) begin
               res.push_refused = 1'b1;
            end else begin
               sq_fill_in = sq_fill_ff + 1'b1;
            end
         end
         REQ_BLOCK: begin
            if (bq_fill_ff == (BAW+1)'(BLOCK_QUEUE_DEPTH)) begin
               res.push_refused = 1'b1;
            end else begin
               bq_fill_in = bq_fill_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
      res.pos_x = px_in; res.pos_y = py_in; res.pos_z = pz_in;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_head_ff <= '0; sq_fill_ff <= '0; bq_head_ff <= '0; bq_fill_ff <= '0;
         bx_ff <= '0; by_ff <= '0; bz_ff <= '0; tc_ff <= '0; rate_ff <= '0;
         ev_ff <= '0; pbits_ff <= '0; ppulse_ff <= 1'b0; lm_ff <= LM_NEXT_BLOCK;
         px_ff <= '0; py_ff <= '0; pz_ff <= '0;
      end else if (fire) begin
         sq_head_ff <= sq_head_in; sq_fill_ff <= sq_fill_in;
         bq_head_ff <= bq_head_in; bq_fill_ff <= bq_fill_in;
         bx_ff <= bx_in; by_ff <= by_in; bz_ff <= bz_in; tc_ff <= tc_in;
         rate_ff <= rate_in; ev_ff <= ev_in; pbits_ff <= pbits_in;
         ppulse_ff <= ppulse_in; lm_ff <= lm_in;
         px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
      end
   end

   // Queue storage writes.
   always_ff @(posedge clock) begin
      if (fire && cmd.kind == REQ_SEG && sq_fill_ff != (SAW+1)'(SEG_QUEUE_DEPTH)) begin
         sq_count_ff[sq_slot] <= COUNT_BITS'(cmd.seg_event_count);
         sq_rate_ff[sq_slot]  <= cmd.seg_rate;
         sq_eob_ff[sq_slot]   <= cmd.seg_end_of_block;
      end
      if (fire && cmd.kind == REQ_BLOCK &&
          bq_fill_ff != (BAW+1)'(BLOCK_QUEUE_DEPTH)) begin
         bq_sx_ff[bq_slot]  <= COUNT_BITS'(cmd.steps_x);
         bq_sy_ff[bq_slot]  <= COUNT_BITS'(cmd.steps_y);
         bq_sz_ff[bq_slot]  <= COUNT_BITS'(cmd.steps_z);
         bq_tot_ff[bq_slot] <= COUNT_BITS'(cmd.total_events);
         bq_dir_ff[bq_slot] <= cmd.direction;
         bq_dn_ff[bq_slot]  <= cmd.d_next;
      end
   end

   // Output queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff <= 1'b0; oq_rd_ff <= 1'b0; oq_cnt_ff <= '0;
      end else begin
         if (fire) oq_wr_ff <= ~oq_wr_ff;
         if (rsp_take && rsp_valid) oq_rd_ff <= ~oq_rd_ff;
         oq_cnt_ff <= oq_cnt_ff + 2'(fire) - 2'(rsp_take && rsp_valid);
      end
   end

   always_ff @(posedge clock) begin
      if (fire) oq_ff[oq_wr_ff] <= res;
   end

   `ITB_ASSERT_IMP(a_fill_seg, clock, reset, 1'b1,
      sq_fill_ff <= (SAW+1)'(SEG_QUEUE_DEPTH), "segment fill over depth")
   `ITB_ASSERT_IMP(a_fill_blk, clock, reset, 1'b1,
      bq_fill_ff <= (BAW+1)'(BLOCK_QUEUE_DEPTH), "block fill over depth")
   `ITB_ASSERT_NEXT(a_oq_cnt, clock, reset, fire && !(rsp_take && rsp_valid),
      oq_cnt_ff == $past(oq_cnt_ff) + 2'd1, "output count did not grow")
endmodule

@@ design/itbsg_csr.sv @@
// Configuration register file.
module itbsg_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [7:0]  flip_mask
);
   import itbsg_pkg::*;

   logic [7:0] mask_ff;
   logic       hit;

   assign hit         = (paddr[1:0] == 2'(REG_FLIP_MASK * 4));
   assign pready      = 1'b1;
   assign flip_mask   = mask_ff;
   assign prdata      = hit ? {24'd0, mask_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (psel && penable && pwrite && hit) begin
         mask_ff <= pwdata[7:0];
      end
   end
endmodule

@@ bench/inverse_time_bresenham_step_generator_tb.sv @@
module inverse_time_bresenham_step_generator_tb;
   import itbsg_pkg::*;

   localparam int SEG_DEPTH   = SEG_QUEUE_DEPTH_DEF;
   localparam int BLOCK_DEPTH = BLOCK_QUEUE_DEPTH_DEF;
   localparam int CB          = COUNT_BITS_DEF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [1:0]            req_req_type = REQ_TICK;
   logic [CB-1:0]         req_seg_event_count = '0;
   logic [29:0]           req_seg_rate = '0;
   logic                  req_seg_end_of_block = 1'b0;
   logic [CB-1:0]         req_block_steps_x = '0;
   logic [CB-1:0]         req_block_steps_y = '0;
   logic [CB-1:0]         req_block_steps_z = '0;
   logic [CB-1:0]         req_block_total_events = '0;
   logic [7:0]            req_block_direction = '0;
   logic [29:0]           req_block_d_next = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [7:0]            rsp_port_bits;
   logic                  rsp_pulse_now;
   logic signed [31:0]    rsp_pos_x;
   logic signed [31:0]    rsp_pos_y;
   logic signed [31:0]    rsp_pos_z;
   logic                  rsp_cycle_stop;
   logic                  rsp_push_refused;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [1:0]            csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   inverse_time_bresenham_step_generator dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Shadow copy of the stepper state.
   logic [7:0]         sh_mask;
   logic signed [25:0] sh_bres [3];
   logic signed [31:0] sh_timer;
   logic [29:0]        sh_rate;
   logic [23:0]        sh_events;
   logic [7:0]         sh_pend_bits;
   bit                 sh_pend_pulse;
   load_mode_type      sh_load;
   logic [23:0]        sh_seg_count [SEG_DEPTH];
   logic [29:0]        sh_seg_rate [SEG_DEPTH];
   bit                 sh_seg_eob [SEG_DEPTH];
   int                 sh_seg_head, sh_seg_fill;
   logic [23:0]        sh_blk_steps [BLOCK_DEPTH][3];
   logic [23:0]        sh_blk_total [BLOCK_DEPTH];
   logic [7:0]         sh_blk_dir [BLOCK_DEPTH];
   logic [29:0]        sh_blk_dnext [BLOCK_DEPTH];
   int                 sh_blk_head, sh_blk_fill;
   logic [31:0]        sh_pos [3];

   rsp_type expected_words [$];
   int      mismatches = 0;
   int      hold_request = 0;

   // One timer tick of the stepper: drive, load, count down, step.
   function automatic void step_tick(ref rsp_type r);
      logic [7:0]         bits;
      logic signed [25:0] nb;
      if (sh_pend_pulse) begin
         r.port_bits = sh_pend_bits;
         r.pulse_now = 1'b1;
         sh_pend_pulse = 0;
      end
      if (sh_load != LM_IDLE) begin
         if (sh_seg_fill == 0 || (sh_load == LM_NEXT_BLOCK && sh_blk_fill == 0)) begin
            r.cycle_stop = 1'b1;
            return;
         end
         sh_events = sh_seg_count[sh_seg_head];
         sh_rate = sh_seg_rate[sh_seg_head];
         if (sh_load == LM_NEXT_BLOCK) begin
            sh_pend_bits = sh_blk_dir[sh_blk_head] ^ sh_mask;
            sh_pend_pulse = 1;
            for (int a = 0; a < 3; a++)
               sh_bres[a] = {3'b0, sh_blk_total[sh_blk_head][23:1]};
            sh_timer = {2'b0, sh_blk_dnext[sh_blk_head]};
         end
         sh_load = LM_IDLE;
      end
      sh_timer = sh_timer - {2'b0, sh_rate};
      if (!sh_timer[31]) return;
      sh_timer = sh_timer + {2'b0, sh_blk_dnext[sh_blk_head]};
      bits = sh_blk_dir[sh_blk_head];
      sh_pend_pulse = 1;
      for (int a = 0; a < 3; a++) begin
         nb = sh_bres[a] - {2'b0, sh_blk_steps[sh_blk_head][a]};
         if (nb[25]) begin
            bits[STEP_X + a] = 1'b1;
            nb = nb + {2'b0, sh_blk_total[sh_blk_head]};
            if (bits[DIR_X + a]) sh_pos[a] = sh_pos[a] - 1;
            else sh_pos[a] = sh_pos[a] + 1;
         end
         sh_bres[a] = nb;
      end
      sh_events = sh_events - 1;
      if (sh_events == 0) begin
         if (sh_seg_eob[sh_seg_head]) begin
            if (sh_blk_fill > 0) begin
               sh_blk_head = (sh_blk_head + 1) % BLOCK_DEPTH;
               sh_blk_fill--;
            end
            sh_load = LM_NEXT_BLOCK;
         end else begin
            sh_load = LM_NEXT_SEG;
         end
         if (sh_seg_fill > 0) begin
            sh_seg_head = (sh_seg_head + 1) % SEG_DEPTH;
            sh_seg_fill--;
         end
      end
      sh_pend_bits = bits ^ sh_mask;
   endfunction

   // Applies one accepted word to the shadow state and returns its result.
   function automatic rsp_type stepper_result(cmd_type c);
      rsp_type r;
      int      slot;
      r = '0;
      case (c.kind)
         REQ_TICK: step_tick(r);
         REQ_SEG: begin
            if (sh_seg_fill >= SEG_DEPTH) begin
               r.push_refused = 1'b1;
            end else begin
               slot = (sh_seg_head + sh_seg_fill) % SEG_DEPTH;
               sh_seg_count[slot] = c.seg_event_count;
               sh_seg_rate[slot] = c.seg_rate;
               sh_seg_eob[slot] = c.seg_end_of_block;
               sh_seg_fill++;
            end
         end
         REQ_BLOCK: begin
            if (sh_blk_fill >= BLOCK_DEPTH) begin
               r.push_refused = 1'b1;
            end else begin
               slot = (sh_blk_head + sh_blk_fill) % BLOCK_DEPTH;
               sh_blk_steps[slot][0] = c.steps_x;
               sh_blk_steps[slot][1] = c.steps_y;
               sh_blk_steps[slot][2] = c.steps_z;
               sh_blk_total[slot] = c.total_events;
               sh_blk_dir[slot] = c.direction;
               sh_blk_dnext[slot] = c.d_next;
               sh_blk_fill++;
            end
         end
         default: ;
      endcase
      r.pos_x = sh_pos[0];
      r.pos_y = sh_pos[1];
      r.pos_z = sh_pos[2];
      return r;
   endfunction

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s expected %h got %h", $realtime, what, want, got);
   endfunction

   // Result side: stall pattern, long hold-off on request, field compare.
   initial begin
      rsp_type want;
      int      hold_left, mode_left, mode;
      logic [7:0] pattern;
      hold_left = 0;
      mode_left = 0;
      mode = 0;
      pattern = 8'hFF;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            if (expected_words.size() == 0) begin
               note_mismatch("unexpected word", '0, '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_port_bits !== want.port_bits)
                  note_mismatch("port_bits", 32'(want.port_bits), 32'(rsp_port_bits));
               if (rsp_pulse_now !== want.pulse_now)
                  note_mismatch("pulse_now", 32'(want.pulse_now), 32'(rsp_pulse_now));
               if (rsp_pos_x !== want.pos_x) note_mismatch("pos_x", want.pos_x, rsp_pos_x);
               if (rsp_pos_y !== want.pos_y) note_mismatch("pos_y", want.pos_y, rsp_pos_y);
               if (rsp_pos_z !== want.pos_z) note_mismatch("pos_z", want.pos_z, rsp_pos_z);
               if (rsp_cycle_stop !== want.cycle_stop)
                  note_mismatch("cycle_stop", 32'(want.cycle_stop), 32'(rsp_cycle_stop));
               if (rsp_push_refused !== want.push_refused)
                  note_mismatch("push_refused", 32'(want.push_refused),
                                32'(rsp_push_refused));
            end
         end
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            pattern = 8'($urandom);
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (mode == 0) begin
            rsp_pop <= 1'b1;
         end else if (mode == 1) begin
            rsp_pop <= 1'($urandom_range(0, 1));
         end else begin
            rsp_pop <= pattern[mode_left % 8];
         end
      end
   end

   // Input side.
   int      burst_left = 4;
   logic [29:0] cur_dnext = 30'd100;

   task automatic offer(cmd_type c, bit typed, rsp_type want);
      rsp_type got;
      req_req_type <= c.kind;
      req_seg_event_count <= c.seg_event_count;
      req_seg_rate <= c.seg_rate;
      req_seg_end_of_block <= c.seg_end_of_block;
      req_block_steps_x <= c.steps_x;
      req_block_steps_y <= c.steps_y;
      req_block_steps_z <= c.steps_z;
      req_block_total_events <= c.total_events;
      req_block_direction <= c.direction;
      req_block_d_next <= c.d_next;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      got = stepper_result(c);
      expected_words.push_back(typed ? want : got);
      if (burst_left == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end else begin
         burst_left--;
      end
   endtask

   // Lets every outstanding word drain with the input held off.
   task automatic drain_all();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the polarity mask through the APB port and reads it back.
   task automatic write_flip_mask(logic [7:0] value);
      drain_all();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 2'(REG_FLIP_MASK * 4);
      csr_pwdata <= {24'($urandom_range(0, 16777215)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sh_mask = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== value)
         note_mismatch("flip mask readback", {24'd0, value}, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic cmd_type make_tick();
      cmd_type c;
      c = '0;
      c.kind = REQ_TICK;
      return c;
   endfunction

   function automatic cmd_type make_seg(logic [23:0] n, logic [29:0] rate, bit eob);
      cmd_type c;
      c = '0;
      c.kind = REQ_SEG;
      c.seg_event_count = n;
      c.seg_rate = rate;
      c.seg_end_of_block = eob;
      return c;
   endfunction

   function automatic cmd_type make_block(logic [23:0] sx, logic [23:0] sy, logic [23:0] sz,
                                          logic [23:0] tot, logic [7:0] dir, logic [29:0] dn);
      cmd_type c;
      c = '0;
      c.kind = REQ_BLOCK;
      c.steps_x = sx;
      c.steps_y = sy;
      c.steps_z = sz;
      c.total_events = tot;
      c.direction = dir;
      c.d_next = dn;
      return c;
   endfunction

   // Random word: mostly ticks and well-formed pushes, some noise.
   function automatic cmd_type random_word();
      cmd_type    c;
      int         pick;
      logic [23:0] tot;
      logic [191:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      c = noise[$bits(cmd_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         c.kind = REQ_NONE;
      end else if (pick < 64) begin
         c.kind = REQ_TICK;
      end else if (pick < 86) begin
         c.kind = REQ_SEG;
         c.seg_event_count = ($urandom_range(0, 15) == 0) ? 24'($urandom_range(1, 40))
                                                          : 24'($urandom_range(1, 4));
         if ($urandom_range(0, 7) == 0) c.seg_rate = 30'($urandom);
         else c.seg_rate = 30'($urandom_range(cur_dnext / 2 + 1, cur_dnext * 2));
         c.seg_end_of_block = ($urandom_range(0, 2) == 0);
      end else begin
         c.kind = REQ_BLOCK;
         if ($urandom_range(0, 9) == 0) begin
            tot = 24'($urandom_range(1, 24'hFFFFFF));
         end else begin
            tot = 24'($urandom_range(1, 20));
            c.steps_x = 24'($urandom_range(0, tot));
            c.steps_y = 24'($urandom_range(0, tot));
            c.steps_z = 24'($urandom_range(0, tot));
         end
         c.total_events = tot;
         if ($urandom_range(0, 7) == 0) begin
            c.d_next = 30'($urandom_range(1, 30'h3FFFFFFF));
         end else begin
            c.d_next = 30'($urandom_range(1, 1000));
            cur_dnext = c.d_next;
         end
      end
      return c;
   endfunction

   typedef struct {
      cmd_type c;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   stim_row_type table_rows [$];

   function automatic void add_row(cmd_type c, bit typed, rsp_type want);
      stim_row_type row;
      row.c = c;
      row.typed = typed;
      row.want = want;
      table_rows.push_back(row);
   endfunction

   initial begin
      rsp_type stop_word, none_word, blank;
      cmd_type odd;
      logic [191:0] noise;
      blank = '0;
      stop_word = '0;
      stop_word.cycle_stop = 1'b1;
      none_word = '0;

      sh_mask = '0;
      for (int a = 0; a < 3; a++) begin
         sh_bres[a] = '0;
         sh_pos[a] = '0;
      end
      sh_timer = '0;
      sh_rate = '0;
      sh_events = '0;
      sh_pend_bits = '0;
      sh_pend_pulse = 0;
      sh_load = LM_NEXT_BLOCK;
      sh_seg_head = 0;
      sh_seg_fill = 0;
      sh_blk_head = 0;
      sh_blk_fill = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-queue stop, ignored type, queue overfill, extremes.
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      odd = noise[$bits(cmd_type)-1:0];
      odd.kind = REQ_NONE;
      add_row(make_tick(), 1, stop_word);
      add_row(odd, 1, none_word);
      add_row(make_block(24'd3, 24'hFFFFFF, 24'd0, 24'd4, 8'hE0, 30'h3FFFFFFF), 0, blank);
      add_row(make_tick(), 1, stop_word);
      add_row(make_block(24'd5, 24'd2, 24'd5, 24'd5, 8'h40, 30'd3), 0, blank);
      add_row(make_block(24'd1, 24'd1, 24'd1, 24'hFFFFFF, 8'h00, 30'd1), 0, blank);
      add_row(make_block(24'd2, 24'd0, 24'd1, 24'd2, 8'hA0, 30'd10), 0, blank);
      add_row(make_block(24'd1, 24'd1, 24'd1, 24'd1, 8'hFF, 30'd5), 0, blank);
      add_row(make_seg(24'd2, 30'h3FFFFFFF, 1'b0), 0, blank);
      add_row(make_seg(24'd1, 30'h3FFFFFFF, 1'b1), 0, blank);
      add_row(make_seg(24'd3, 30'd2, 1'b1), 0, blank);
      add_row(make_seg(24'd1, 30'd1, 1'b1), 0, blank);
      for (int i = 0; i < 12; i++) add_row(make_tick(), 0, blank);
      foreach (table_rows[i]) offer(table_rows[i].c, table_rows[i].typed, table_rows[i].want);

      // Random phases under several mask settings.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: write_flip_mask(8'hFF);
            1: write_flip_mask(8'h00);
            default: write_flip_mask(8'($urandom_range(0, 255)));
         endcase
         for (int i = 0; i < 300; i++) begin
            if (phase == 1 && i == 100) hold_request = 120;
            if (phase == 2 && i == 150) drain_all();
            offer(random_word(), 0, blank);
         end
      end

      // Longest count with a rate of zero parks the stepper for good.
      offer(make_block(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 30'h3FFFFFFF),
            0, blank);
      offer(make_seg(24'hFFFFFF, 30'd0, 1'b1), 0, blank);
      for (int i = 0; i < 20; i++) offer(make_tick(), 0, blank);

      drain_all();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/itbsg_pkg.sv
design/itbsg_front.sv
design/itbsg_back.sv
design/itbsg_csr.sv
design/inverse_time_bresenham_step_generator.sv
bench/inverse_time_bresenham_step_generator_tb.sv
